// File: rtl/fatte_pkg.sv
`default_nettype none

package fatte_pkg;

    // Table geometry
    localparam int TABLE_BYTES = 65536;
    localparam int AW          = $clog2(TABLE_BYTES);
    // Wide enough for a FAT32 byte address of any 16-bit cluster plus four bytes
    localparam int EAW         = ((AW > 18) ? AW : 18) + 1;

    localparam int CW          = 28;   // entry and cluster count width
    localparam int IW          = 16;   // index field width

    // Format thresholds on the cluster count
    localparam logic [CW-1:0] FAT16_MIN = CW'(4085);
    localparam logic [CW-1:0] FAT32_MIN = CW'(65525);

    // Entry marks
    localparam logic [CW-1:0] EOC12 = CW'(32'h0FF8);
    localparam logic [CW-1:0] EOC16 = CW'(32'hFFF8);
    localparam logic [CW-1:0] EOC32 = CW'(32'h0FFFFFF8);
    localparam logic [CW-1:0] BAD12 = CW'(32'h0FF7);
    localparam logic [CW-1:0] BAD16 = CW'(32'hFFF7);
    localparam logic [CW-1:0] BAD32 = CW'(32'h0FFFFFF7);

    typedef enum logic [1:0] {
        FMT12 = 2'd0,
        FMT16 = 2'd1,
        FMT32 = 2'd2
    } t_fmt;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_READ  = 2'd1,
        KIND_WRITE = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_REFUSED = 2'd1,
        ST_RANGE   = 2'd2
    } t_status;

    typedef struct packed {
        logic eoc;
        logic bad;
        logic free;
    } t_flags;

endpackage

`default_nettype wire

// File: rtl/fatte_if.sv
`default_nettype none

// Request channel: one table operation per word
interface fatte_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] index;
    logic [27:0] write_value;

    modport source (output valid, output kind, output index, output write_value, input ready);
    modport sink   (input valid, input kind, input index, input write_value, output ready);
endinterface

// Response channel: one result word per request
interface fatte_rsp_if;
    logic        valid;
    logic        ready;
    logic [27:0] entry_value;
    logic        end_of_chain;
    logic        bad_cluster;
    logic        free_cluster;
    logic [1:0]  status;

    modport source (output valid, output entry_value, output end_of_chain,
                    output bad_cluster, output free_cluster, output status, input ready);
    modport sink   (input valid, input entry_value, input end_of_chain,
                    input bad_cluster, input free_cluster, input status, output ready);
endinterface

`default_nettype wire

// File: rtl/fatte_flags.sv
`default_nettype none

// Classify an entry as free (zero), end of chain (zero, or at or above the end-of-chain mark of its format) or bad
module fatte_flags (
    input  var fatte_pkg::t_fmt              i_fmt,
    input  var logic [fatte_pkg::CW-1:0]     i_entry,
    output var fatte_pkg::t_flags            o_flags
);

    logic [fatte_pkg::CW-1:0] eoc_mark;
    logic [fatte_pkg::CW-1:0] bad_mark;

    always_comb begin
        case (i_fmt)
            fatte_pkg::FMT12: begin
                eoc_mark = fatte_pkg::EOC12;
                bad_mark = fatte_pkg::BAD12;
            end
            fatte_pkg::FMT16: begin
                eoc_mark = fatte_pkg::EOC16;
                bad_mark = fatte_pkg::BAD16;
            end
            default: begin
                eoc_mark = fatte_pkg::EOC32;
                bad_mark = fatte_pkg::BAD32;
            end
        endcase
    end

    assign o_flags.free = (i_entry == '0);
    assign o_flags.eoc  = (i_entry == '0) || (i_entry >= eoc_mark);
    assign o_flags.bad  = (i_entry == bad_mark);

endmodule

`default_nettype wire

// File: rtl/fat_table_entry_engine_core.sv
`default_nettype none

// File allocation table entry engine. Holds a 64 KiB byte-wide table in a
// single-port memory and serves one request word at a time: load a raw byte,
// read a cluster entry, or write one. The entry format follows the cluster
// total register (below 4085 FAT12, below 65525 FAT16, else FAT32); write the
// register only while the engine is idle. Entries are little-endian and are
// moved one byte per cycle through the table's single port, which sets the rate.
// A byte load, an unused kind or an out-of-table request goes straight to the
// finish step; a read gathers 2 (FAT12/FAT16) or 4 (FAT32) bytes, then extracts,
// checks and finishes; a write also stores the merged bytes. The request side is
// ready only while the sequencer is idle; a finished result sits in an output
// register, so the next request may be taken while it waits to be collected.
// A write to a bad entry is refused with status 1 and leaves the table alone;
// any entry reaching past the end of the table gives status 2 and all-zero
// fields. The table has no reset: reading bytes never loaded or written
// returns undefined data.
module fat_table_entry_engine_core (
    input  var logic                        i_clk,
    input  var logic                        i_rst_n,
    fatte_req_if.sink                       i_req,
    fatte_rsp_if.source                     o_rsp,
    input  var logic                        i_cfg_we,
    input  var logic [fatte_pkg::CW-1:0]    i_cfg_wdata
);

    localparam int AW  = fatte_pkg::AW;
    localparam int EAW = fatte_pkg::EAW;
    localparam int CW  = fatte_pkg::CW;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RD   = 6'b000010,
        S_EXT  = 6'b000100,
        S_CHK  = 6'b001000,
        S_WR   = 6'b010000,
        S_FIN  = 6'b100000
    } t_state;

    // Control
    t_state              r_state, n_state;
    logic [CW-1:0]       r_clus_total;
    logic                r_out_valid, n_out_valid;

    // Item context
    fatte_pkg::t_kind    r_kind;
    fatte_pkg::t_fmt     r_fmt;
    logic                r_odd;
    logic [CW-1:0]       r_val;
    logic [AW-1:0]       r_addr;
    logic [1:0]          r_last;
    logic [1:0]          r_cnt;
    logic [31:0]         r_word;
    logic [CW-1:0]       r_entry;
    logic                r_quiet;
    fatte_pkg::t_status  r_status;

    // Output register
    logic [CW-1:0]       r_out_entry;
    fatte_pkg::t_flags   r_out_flags;
    fatte_pkg::t_status  r_out_status;

    // Table
    logic [7:0]          mem [fatte_pkg::TABLE_BYTES];
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [7:0]          mem_wdata;
    logic                mem_re;
    logic [AW-1:0]       seq_addr;

    // Accept-time decode
    logic                accept;
    fatte_pkg::t_fmt     acc_fmt;
    logic [EAW-1:0]      ext_idx;
    logic [EAW-1:0]      ext_addr;
    logic [EAW-1:0]      ext_end;
    logic [1:0]          acc_last;
    logic                acc_oor;
    logic                load_in_range;

    // Entry handling
    fatte_pkg::t_flags   flags;
    logic [CW-1:0]       old_entry;
    logic [CW-1:0]       new_entry;
    logic [31:0]         merged_word;
    logic                fin_go;

    assign accept = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);

    // Pick the format from the cluster total
    always_comb begin
        if (r_clus_total < fatte_pkg::FAT16_MIN) begin
            acc_fmt = fatte_pkg::FMT12;
        end else if (r_clus_total < fatte_pkg::FAT32_MIN) begin
            acc_fmt = fatte_pkg::FMT16;
        end else begin
            acc_fmt = fatte_pkg::FMT32;
        end
    end

    // First byte of the entry and its last lane; check it fits the table
    assign ext_idx = EAW'(i_req.index);
    always_comb begin
        case (acc_fmt)
            fatte_pkg::FMT12: begin
                ext_addr = ext_idx + (ext_idx >> 1);
                acc_last = 2'd1;
            end
            fatte_pkg::FMT16: begin
                ext_addr = ext_idx << 1;
                acc_last = 2'd1;
            end
            default: begin
                ext_addr = ext_idx << 2;
                acc_last = 2'd3;
            end
        endcase
    end
    assign ext_end       = ext_addr + EAW'(acc_last) + EAW'(1);
    assign acc_oor       = ext_end > EAW'(fatte_pkg::TABLE_BYTES);
    assign load_in_range = ext_idx < EAW'(fatte_pkg::TABLE_BYTES);

    // The one byte-address adder walks the lanes of the entry
    assign seq_addr = r_addr + AW'(r_cnt);

    // Memory port control: byte loads write straight from the request word
    always_comb begin
        mem_re = (r_state == S_RD);
        if (accept && (i_req.kind == fatte_pkg::KIND_LOAD) && load_in_range) begin
            mem_we    = 1'b1;
            mem_waddr = AW'(ext_idx);
            mem_wdata = i_req.write_value[7:0];
        end else begin
            mem_we    = (r_state == S_WR);
            mem_waddr = seq_addr;
            mem_wdata = r_word[8*r_cnt +: 8];
        end
    end

    // Pull the entry out of the assembled word
    always_comb begin
        case (r_fmt)
            fatte_pkg::FMT12: old_entry = r_odd ? CW'(r_word[15:4]) : CW'(r_word[11:0]);
            fatte_pkg::FMT16: old_entry = CW'(r_word[15:0]);
            default:          old_entry = r_word[CW-1:0];
        endcase
    end

    // Merge the new value into the stored word; keep the neighbour nibble or top bits
    always_comb begin
        merged_word = r_word;
        case (r_fmt)
            fatte_pkg::FMT12: begin
                new_entry = CW'(r_val[11:0]);
                if (r_odd) begin
                    merged_word[15:0] = {r_val[11:0], r_word[3:0]};
                end else begin
                    merged_word[15:0] = {r_word[15:12], r_val[11:0]};
                end
            end
            fatte_pkg::FMT16: begin
                new_entry         = CW'(r_val[15:0]);
                merged_word[15:0] = r_val[15:0];
            end
            default: begin
                new_entry   = r_val;
                merged_word = {r_word[31:CW], r_val};
            end
        endcase
    end

    // Shared flag unit: always looks at the held entry
    fatte_flags u_flags (
        .i_fmt   (r_fmt),
        .i_entry (r_entry),
        .o_flags (flags)
    );

    assign fin_go = (r_state == S_FIN) && (!r_out_valid || o_rsp.ready);

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (((i_req.kind == fatte_pkg::KIND_READ) ||
                         (i_req.kind == fatte_pkg::KIND_WRITE)) && !acc_oor) begin
                        n_state = S_RD;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_RD: begin
                if (r_cnt == r_last) begin
                    n_state = S_EXT;
                end
            end
            S_EXT: n_state = S_CHK;
            S_CHK: begin
                if ((r_kind == fatte_pkg::KIND_WRITE) && !flags.bad) begin
                    n_state = S_WR;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_WR: begin
                if (r_cnt == r_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (fin_go) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Output word holds until taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (fin_go) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_clus_total <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_clus_total <= i_cfg_wdata;
            end
        end
    end

    // Item context and lane counter
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_kind   <= fatte_pkg::t_kind'(i_req.kind);
                r_fmt    <= acc_fmt;
                r_odd    <= i_req.index[0];
                r_val    <= i_req.write_value;
                r_addr   <= AW'(ext_addr);
                r_last   <= acc_last;
                r_cnt    <= '0;
                r_entry  <= '0;
                r_quiet  <= 1'b1;
                r_status <= fatte_pkg::ST_OK;
                if (i_req.kind == fatte_pkg::KIND_LOAD) begin
                    if (!load_in_range) begin
                        r_status <= fatte_pkg::ST_RANGE;
                    end
                end else if ((i_req.kind == fatte_pkg::KIND_READ) ||
                             (i_req.kind == fatte_pkg::KIND_WRITE)) begin
                    if (acc_oor) begin
                        r_status <= fatte_pkg::ST_RANGE;
                    end
                end
            end
            S_RD, S_WR: begin
                r_cnt <= (r_cnt == r_last) ? 2'd0 : r_cnt + 2'd1;
            end
            S_EXT: begin
                r_entry <= old_entry;
                r_quiet <= 1'b0;
            end
            S_CHK: begin
                if (r_kind == fatte_pkg::KIND_WRITE) begin
                    if (flags.bad) begin
                        r_status <= fatte_pkg::ST_REFUSED;
                    end else begin
                        r_entry <= new_entry;
                    end
                end
            end
            default: begin
            end
        endcase

        if (fin_go) begin
            r_out_entry  <= r_entry;
            r_out_flags  <= r_quiet ? '0 : flags;
            r_out_status <= r_status;
        end
    end

    // Table port; read data lands in its lane of the assembled word
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_word[8*r_cnt +: 8] <= mem[seq_addr];
        end else if ((r_state == S_CHK) && (r_kind == fatte_pkg::KIND_WRITE) && !flags.bad) begin
            r_word <= merged_word;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.entry_value  = r_out_entry;
    assign o_rsp.end_of_chain = r_out_flags.eoc;
    assign o_rsp.bad_cluster  = r_out_flags.bad;
    assign o_rsp.free_cluster = r_out_flags.free;
    assign o_rsp.status       = r_out_status;

`ifndef SYNTH
    // The table is never written while an entry is being gathered or checked
    a_no_write_midread: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_RD) || (r_state == S_EXT) || (r_state == S_CHK)) |-> !mem_we)
        else $error("table written while an entry is being read");

    // A new result word only comes out of the finish step
    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_FIN))
        else $error("result word raised outside the finish step");

    // A refused write always reports the bad flag of the stored entry
    a_refused_is_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == fatte_pkg::ST_REFUSED)) |-> r_out_flags.bad)
        else $error("refused write without bad flag");

    // An out-of-table result carries nothing
    a_range_is_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == fatte_pkg::ST_RANGE)) |->
        ((r_out_entry == '0) && (r_out_flags == '0)))
        else $error("out-of-table result with data");
`endif

endmodule

`default_nettype wire
